// ===== sv/led_blink_pattern_sequencer_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef LED_BLINK_PATTERN_SEQUENCER_TOP_MACROS_SVH
`define LED_BLINK_PATTERN_SEQUENCER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== sv/lbps_pkg.sv =====
`timescale 1ns / 1ps

package lbps_pkg;

    // Pattern geometry.
    localparam int SEGMENTS    = 8;
    localparam int LENGTH_BITS = 4;
    localparam int PATTERN_W   = 32;
    localparam int POS_W       = $clog2(SEGMENTS + 1);
    localparam int IDX_W       = 4;

    // Action codes carried by an input item.
    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_ONCE = 2'd1,
        ACT_LOOP = 2'd2
    } action_t;

    // Input item.
    typedef struct packed {
        logic [1:0]           action;
        logic [PATTERN_W-1:0] blink_pattern;
    } item_t;

    // Result item.
    typedef struct packed {
        logic             led_on;
        logic [IDX_W-1:0] segment_index;
    } result_t;

    // Length of the segment at a position; positions past the end or
    // fields starting beyond the pattern word read as zero.
    function automatic logic [LENGTH_BITS-1:0] seg_len(
        input logic [PATTERN_W-1:0] pattern,
        input logic [POS_W-1:0]     pos
    );
        logic [LENGTH_BITS-1:0] len;
        len = '0;
        for (int i = 0; i < SEGMENTS; i++) begin
            if (pos == POS_W'(i) && i * LENGTH_BITS < PATTERN_W) begin
                len = LENGTH_BITS'(pattern >> (i * LENGTH_BITS));
            end
        end
        return len;
    endfunction

endpackage

// ===== sv/lbps_core.sv =====
`timescale 1ns / 1ps

module lbps_core
    import lbps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    take,
    input  item_t   item,
    output result_t result
);

    logic [PATTERN_W-1:0]   stored_pattern_reg, stored_pattern_next;
    logic [POS_W-1:0]       position_reg, position_next;
    logic                   once_pending_reg, once_pending_next;
    logic                   loop_mode_reg, loop_mode_next;
    logic [LENGTH_BITS-1:0] ticks_left_reg, ticks_left_next;
    logic                   led_level_reg, led_level_next;
    logic [LENGTH_BITS-1:0] len;

    assign len = seg_len(stored_pattern_reg, position_reg);

    // Next state for the item being transferred.
    always_comb
    begin
        stored_pattern_next = stored_pattern_reg;
        position_next       = position_reg;
        once_pending_next   = once_pending_reg;
        loop_mode_next      = loop_mode_reg;
        ticks_left_next     = ticks_left_reg;
        led_level_next      = led_level_reg;
        unique case (item.action)
            ACT_TICK:
            begin
                if (ticks_left_reg != '0) begin
                    ticks_left_next = ticks_left_reg - 1'b1;
                end else if (len != '0) begin
                    // Even segments light the LED, odd ones turn it off.
                    led_level_next  = ~position_reg[0];
                    position_next   = position_reg + 1'b1;
                    ticks_left_next = len - 1'b1;
                end else begin
                    // End of pattern: restart if requested, idle this tick.
                    if (loop_mode_reg || once_pending_reg) begin
                        position_next = '0;
                    end
                    once_pending_next = 1'b0;
                end
            end
            ACT_ONCE:
            begin
                stored_pattern_next = item.blink_pattern;
                loop_mode_next      = 1'b0;
                once_pending_next   = 1'b1;
            end
            ACT_LOOP:
            begin
                stored_pattern_next = item.blink_pattern;
                loop_mode_next      = 1'b1;
            end
            default:
            begin
                // Unused code: state is left alone.
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stored_pattern_reg <= '0;
            position_reg       <= POS_W'(SEGMENTS);
            once_pending_reg   <= 1'b0;
            loop_mode_reg      <= 1'b0;
            ticks_left_reg     <= '0;
            led_level_reg      <= 1'b0;
        end else if (take) begin
            stored_pattern_reg <= stored_pattern_next;
            position_reg       <= position_next;
            once_pending_reg   <= once_pending_next;
            loop_mode_reg      <= loop_mode_next;
            ticks_left_reg     <= ticks_left_next;
            led_level_reg      <= led_level_next;
        end
    end

    // The result shows the state after this item.
    assign result.led_on        = led_level_next;
    assign result.segment_index = IDX_W'(position_next);

endmodule

// ===== sv/led_blink_pattern_sequencer_top.sv =====
`timescale 1ns / 1ps
// Output: each result is registered and appears in the cycle after its item's transfer.
// Throughput: one item per cycle; the input stalls only while a result is
// held and the output side stalls.
// Reset: asynchronous, active low; the pattern is finished, the LED is off,
// no pattern is stored and no result is pending.

module led_blink_pattern_sequencer_top
    import lbps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic    take;
    logic    result_valid_reg;
    result_t result_reg;
    result_t core_result;

    // An item may enter whenever the output register is free or draining.
    assign item_stall = result_valid_reg && result_stall;
    assign take       = item_valid && !item_stall;

    lbps_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (item),
        .result (core_result)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            result_valid_reg <= 1'b0;
        end else if (take) begin
            result_valid_reg <= 1'b1;
        end else if (!result_stall) begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            result_reg <= core_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== sv/lbps_checker.sv =====
`timescale 1ns / 1ps
`include "led_blink_pattern_sequencer_top_macros.svh"

module lbps_checker
    import lbps_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input item_t   item,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // The segment index never passes the finished position.
    `ASSERT_IMP(a_index_range, result_valid, result.segment_index <= IDX_W'(SEGMENTS))

    // Every transfer in produces a result in the next cycle.
    `ASSERT_NEXT(a_result_follows, item_valid && !item_stall, result_valid)

    // The input stalls only behind a held result.
    `ASSERT_IMP(a_stall_cause, item_stall, result_valid && result_stall)

    // A stalled result holds.
    `ASSERT_NEXT(a_result_holds, result_valid && result_stall, result_valid && $stable(result))

    // A command leaves the LED and the position as they were.
    `ASSERT_NEXT(a_cmd_keeps_state, item_valid && !item_stall && result_valid && item.action != ACT_TICK, result == $past(result))

endmodule

bind led_blink_pattern_sequencer_top lbps_checker u_lbps_checker (.*);
